// ===== design/value_noise_smootherstep_interp_unit_assert.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef VALUE_NOISE_SMOOTHERSTEP_INTERP_UNIT_ASSERT_SVH
`define VALUE_NOISE_SMOOTHERSTEP_INTERP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VNSI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VNSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vnsi_pkg.sv =====
`timescale 1ns / 1ps
package vnsi_pkg;

  // Fraction constants in Q1.16
  localparam logic [16:0] T_ONE16    = 17'h10000;
  localparam logic [16:0] STEP_MIN   = 17'd1024;
  localparam logic [16:0] STEP_RESET = 17'd1311;
  // Index of the last sample a segment may have
  localparam logic [5:0]  SEG_LAST   = 6'd63;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_TT,
    ST_T3,
    ST_Q,
    ST_S,
    ST_R,
    ST_OUT
  } st_t;

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_TT,
    SEL_T3,
    SEL_S,
    SEL_R
  } mul_sel_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    mul_sel_t sel;
    logic     ld_tt;
    logic     ld_t3;
    logic     ld_q;
    logic     ld_out;
    logic     ld_first;
  } ctrl_t;

endpackage

// ===== design/vnsi_mul.sv =====
`timescale 1ns / 1ps
module vnsi_mul
  import vnsi_pkg::*;
#(
  parameter int W = 20
) (
  input  logic           clk,
  input  logic           ce,
  input  logic [W-1:0]   op_a,
  input  logic [W-1:0]   op_b,
  output logic [2*W-1:0] prod
);

  // Registered product, held while no operation is issued
  always_ff @(posedge clk) begin
    if (ce) begin
      prod <= op_a * op_b;
    end
  end

endmodule

// ===== design/vnsi_ctrl.sv =====
`timescale 1ns / 1ps
module vnsi_ctrl
  import vnsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  have_prev,
  input  logic  last,
  input  logic  out_free,
  output logic  in_ready,
  output ctrl_t ctl
);

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = have_prev ? ST_TT : ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TT: state_next = ST_T3;
      ST_T3: state_next = ST_Q;
      ST_Q:  state_next = ST_S;
      ST_S:  state_next = ST_R;
      ST_R:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = last ? ST_IDLE : ST_TT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.sel      = SEL_NONE;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_FIRST: ctl.ld_first = out_free;
      ST_TT:    ctl.sel = SEL_TT;
      ST_T3: begin
        ctl.sel   = SEL_T3;
        ctl.ld_tt = 1'b1;
      end
      ST_Q: begin
        ctl.ld_t3 = 1'b1;
        ctl.ld_q  = 1'b1;
      end
      ST_S:   ctl.sel = SEL_S;
      ST_R:   ctl.sel = SEL_R;
      ST_OUT: ctl.ld_out = out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ===== design/value_noise_smootherstep_interp_unit.sv =====
`timescale 1ns / 1ps
// The first value after reset passes through state ST_FIRST to the output register.
// Each segment sample steps through the shared multiplier in order (t*t, t2*t,
// quintic sum, t3*q, delta*S, output load); the input is held off for a whole segment,
// and an output stall holds the sequencer in its output or first state.
// Reset (rst, synchronous): sequencer idle, fade_step 1311, no previous value.
`include "value_noise_smootherstep_interp_unit_assert.svh"
module value_noise_smootherstep_interp_unit
  import vnsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,       // fade_step
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // lattice_value
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample
  output logic        m_axis_tlast    // segment_end
);

  localparam int TW   = FRAC_BITS + 1;
  localparam int QW   = FRAC_BITS + 4;
  localparam int MW   = (FRAC_BITS + 4 > 16) ? FRAC_BITS + 4 : 16;
  localparam int PW   = 2 * MW;
  localparam int TTW  = 2 * FRAC_BITS + 2;
  localparam int SUMW = 2 * FRAC_BITS + 6;
  localparam int SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [PW-1:0]   HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0]   ONE_P  = PW'(1) << FRAC_BITS;
  localparam logic [TW-1:0]   ONE_T  = TW'(1) << FRAC_BITS;
  localparam logic [SUMW-1:0] HALF_S = SUMW'(1) << (FRAC_BITS - 1);
  localparam logic [SUMW-1:0] TEN_S  = SUMW'(10) << (2 * FRAC_BITS);

  ctrl_t ctl;
  logic  in_fire, out_free;

  // Config register, writable any time the block is idle
  logic [16:0] fade_step, step_eff;
  assign cfg_ready = s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_step <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fade_step <= cfg_data;
    end
  end

  assign step_eff = (fade_step < STEP_MIN) ? STEP_MIN : fade_step;

  // Lattice state
  logic        have_prev;
  logic [15:0] prev, a_r, b_r, d_r;
  logic        dge;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev      <= '0;
    end else if (in_fire) begin
      have_prev <= 1'b1;
      prev      <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r <= prev;
      b_r <= s_axis_tdata;
      dge <= (s_axis_tdata >= prev);
      d_r <= (s_axis_tdata >= prev) ? s_axis_tdata - prev : prev - s_axis_tdata;
    end
  end

  // Fraction position within the segment
  logic [16:0] t_cur, t_base;
  logic [5:0]  n, n_val;
  logic        last_r, last_v, t_adv;
  logic [17:0] t_raw;

  assign t_adv  = (in_fire && have_prev) || (ctl.ld_out && !last_r);
  assign t_base = in_fire ? 17'd0 : t_cur;
  assign n_val  = in_fire ? 6'd0 : n + 6'd1;
  assign t_raw  = {1'b0, t_base} + {1'b0, step_eff};
  assign last_v = (t_raw >= {1'b0, T_ONE16}) || (n_val == SEG_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_cur  <= '0;
      n      <= '0;
      last_r <= 1'b0;
    end else if (t_adv) begin
      t_cur  <= last_v ? T_ONE16 : t_raw[16:0];
      n      <= n_val;
      last_r <= last_v;
    end
  end

  // Sequencer
  vnsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .have_prev(have_prev),
    .last     (last_r),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .ctl      (ctl)
  );

  // t rescaled to FRAC_BITS fractional bits
  logic [TW-1:0] tf;
  always_comb begin
    if (FRAC_BITS >= 16) begin
      tf = TW'(t_cur) << SHL;
    end else begin
      tf = TW'(t_cur >> SHR);
    end
  end

  // Shared multiplier and rounding of its product
  logic [MW-1:0] op_a, op_b;
  logic [PW-1:0] prod, prod_rnd;
  logic [TW-1:0] s_comb;

  assign prod_rnd = (prod + HALF_P) >> FRAC_BITS;
  assign s_comb   = (prod_rnd > ONE_P) ? ONE_T : TW'(prod_rnd);

  logic [TTW-1:0] tt;
  logic [TW-1:0]  t3;
  logic [QW-1:0]  q;

  always_comb begin
    case (ctl.sel)
      SEL_TT: begin
        op_a = MW'(tf);
        op_b = MW'(tf);
      end
      SEL_T3: begin
        op_a = MW'(TW'(prod_rnd));
        op_b = MW'(tf);
      end
      SEL_S: begin
        op_a = MW'(t3);
        op_b = MW'(q);
      end
      SEL_R: begin
        op_a = MW'(s_comb);
        op_b = MW'(d_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  vnsi_mul #(.W(MW)) u_mul (
    .clk (clk),
    .ce  (ctl.sel != SEL_NONE),
    .op_a(op_a),
    .op_b(op_b),
    .prod(prod)
  );

  // Quintic factor q = 6t^2 - 15t + 10 from the exact t*t
  logic [SUMW-1:0] tt_s, tf_s, q_sum;
  assign tt_s  = SUMW'(tt);
  assign tf_s  = SUMW'(tf);
  assign q_sum = (tt_s << 2) + (tt_s << 1) + TEN_S + HALF_S
               - (((tf_s << 4) - tf_s) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ctl.ld_tt) begin
      tt <= TTW'(prod);
    end
    if (ctl.ld_t3) begin
      t3 <= TW'(prod_rnd);
    end
    if (ctl.ld_q) begin
      q <= QW'(q_sum >> FRAC_BITS);
    end
  end

  // Blend and saturate
  logic [16:0] r;
  logic [17:0] up_sum, dn_diff;
  logic [15:0] sample_next;

  assign r       = 17'(prod_rnd);
  assign up_sum  = {2'b00, a_r} + {1'b0, r};
  assign dn_diff = {2'b00, a_r} - {1'b0, r};

  always_comb begin
    if (dge) begin
      sample_next = (up_sum > 18'd65535) ? 16'hFFFF : up_sum[15:0];
    end else begin
      sample_next = dn_diff[17] ? 16'h0000 : dn_diff[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.ld_out || ctl.ld_first) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_first) begin
      m_axis_tdata <= b_r;
      m_axis_tlast <= 1'b1;
    end else if (ctl.ld_out) begin
      m_axis_tdata <= sample_next;
      m_axis_tlast <= last_r;
    end
  end

  // Checks
  `VNSI_ASSERT_SAME(a_t_clamped, clk, rst, !s_axis_tready, t_cur <= T_ONE16, "t beyond one")
  `VNSI_ASSERT_NEXT(a_end_is_b, clk, rst, ctl.ld_out && last_r,
                    m_axis_tdata == $past(b_r), "segment end differs from target value")
  `VNSI_ASSERT_NEXT(a_end_idle, clk, rst, ctl.ld_out && last_r,
                    s_axis_tready, "not idle after segment end")

endmodule

// ===== dv/value_noise_smootherstep_interp_unit_tb.sv =====
`timescale 1ns / 1ps
module value_noise_smootherstep_interp_unit_tb
  import vnsi_pkg::*;
;

  localparam int FRAC_BITS   = 16;
  localparam int HOLD_CYCLES = 300;   // long output back-pressure stretch
  localparam int SETTLE      = 8;     // idle cycles before a register write
  localparam int STALL_LIMIT = 6000;  // cycles with no transaction at all
  localparam int REPORT_MAX  = 10;

  // Expected-sample store plus a bit-accurate interpolator model
  class vn_scoreboard;
    logic [16:0]  fade_step = STEP_RESET;
    logic [15:0]  prev_lattice = '0;
    bit           primed = 1'b0;
    logic [15:0]  exp_sample[$];
    bit           exp_end[$];
    int           errors = 0;
    int           lattice_cnt = 0;
    int           sample_cnt = 0;

    // Q0.32 product back to Q0.16, round half up
    function longint unsigned round_frac(longint unsigned v);
      return (v + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    // 6t^5 - 15t^4 + 10t^3, evaluated as t^3 * (6t^2 - 15t + 10)
    function longint unsigned fade_curve(longint unsigned t);
      longint unsigned one, t2, t3, q, s;
      one = 64'd1 << FRAC_BITS;
      t2  = round_frac(t * t);
      t3  = round_frac(t2 * t);
      q   = round_frac(6 * t * t + 10 * one * one - 15 * t * one);
      s   = round_frac(t3 * q);
      return (s > one) ? one : s;
    endfunction

    function logic [15:0] blend(logic [15:0] a, logic [15:0] b, int unsigned t16);
      longint unsigned s;
      longint          r;
      s = fade_curve(longint'(t16) << (FRAC_BITS - 16));
      if (b >= a)
        r = longint'(a) + longint'(round_frac(longint'(b - a) * s));
      else
        r = longint'(a) - longint'(round_frac(longint'(a - b) * s));
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return r[15:0];
    endfunction

    function void set_step(logic [16:0] v);
      fade_step = v;
    endfunction

    // Accepted lattice value: queue up every sample of its segment
    function void note_lattice(logic [15:0] b);
      logic [15:0] a;
      int unsigned stride, t;
      bit          last;
      a = prev_lattice;
      stride = 32'((fade_step < STEP_MIN) ? STEP_MIN : fade_step);
      t = 0;
      prev_lattice = b;
      lattice_cnt++;
      if (!primed) begin
        primed = 1'b1;
        exp_sample.push_back(b);
        exp_end.push_back(1'b1);
        return;
      end
      for (int n = 0; n <= SEG_LAST; n++) begin
        t += stride;
        last = (t >= T_ONE16) || (n == SEG_LAST);
        if (last) t = 32'(T_ONE16);
        exp_sample.push_back(blend(a, b, t));
        exp_end.push_back(last);
        if (last) break;
      end
    endfunction

    function void check_sample(logic [15:0] sample, logic seg_end);
      logic [15:0] want_s;
      bit          want_e;
      sample_cnt++;
      if (exp_sample.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: unexpected sample %h tlast %b", sample, seg_end);
        return;
      end
      want_s = exp_sample.pop_front();
      want_e = exp_end.pop_front();
      if (sample !== want_s || seg_end !== want_e) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: sample #%0d exp %h/%b got %h/%b",
                   sample_cnt, want_s, want_e, sample, seg_end);
      end
    endfunction

    function int pending();
      return exp_sample.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;        // fade_step
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // lattice_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // sample
  logic        m_axis_tlast;         // segment_end

  vn_scoreboard sb;
  int          src_idle = 0;
  int          snk_idle = 0;
  bit          hold_go = 1'b0;
  int          stall_cycles = 0;
  int          step_settings = 0;
  logic [15:0] last_sent = '0;

  value_noise_smootherstep_interp_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Transaction monitor: register writes, lattice values, samples
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_step(cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_lattice(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata, m_axis_tlast);
    end
  end

  // Receiver: random back-pressure, or one long hold when requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Count cycles without any transaction
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d samples outstanding",
             STALL_LIMIT, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one lattice value, leaving tvalid high after the transaction
  task automatic send_lattice(logic [15:0] v);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    last_sent = v;
  endtask

  // Stop sending and wait for every outstanding sample
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_fade_step(logic [16:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    step_settings++;
  endtask

  // Mostly random values, some small moves, repeats and full-scale jumps
  function automatic logic [15:0] pick_lattice();
    int d;
    case ($urandom_range(9))
      6, 7: begin
        d = int'(last_sent) + int'($urandom_range(512)) - 256;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[15:0];
      end
      8: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      9: return last_sent;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_phase(logic [16:0] step, int n, int sp, int rp, bit squeeze,
                              bit pause);
    write_fade_step(step);
    src_idle = sp;
    snk_idle = rp;
    if (squeeze) hold_go = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (pause && i == n / 2) drain();
      send_lattice(pick_lattice());
    end
  endtask

  initial begin
    logic [15:0] seg_vals[10];
    sb = new;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first value, full swings, equal values, near-midscale
    src_idle = 36;
    snk_idle = 59;
    seg_vals = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};
    foreach (seg_vals[i]) send_lattice(seg_vals[i]);
    // Step of exactly one: a single sample per segment
    write_fade_step(17'h10000);
    send_lattice(16'h1234);
    send_lattice(16'hFEDC);
    send_lattice(16'h0000);
    // Zero step runs as the minimum, 64 samples
    write_fade_step(17'h00000);
    send_lattice(16'hFFFF);
    send_lattice(16'h0000);
    // All step bits set
    write_fade_step(17'h1FFFF);
    send_lattice(16'hAAAA);
    send_lattice(16'h5555);
    write_fade_step(STEP_MIN);
    send_lattice(16'h0000);
    send_lattice(16'hFFFF);

    // Random part across step settings and idling patterns
    random_phase(STEP_MIN, 12, 36, 59, 1'b1, 1'b0);
    random_phase(17'($urandom_range(1025, 8191)), 30, 36, 59, 1'b0, 1'b0);
    random_phase(17'($urandom_range(8192, 65535)), 40, 36, 59, 1'b0, 1'b0);
    random_phase(17'h10000, 30, 36, 59, 1'b0, 1'b0);
    random_phase(17'($urandom_range(0, 1023)), 10, 59, 36, 1'b0, 1'b0);
    random_phase(17'($urandom_range(65537, 131071)), 30, 59, 36, 1'b0, 1'b1);
    random_phase(17'($urandom_range(131071)), 40, 59, 36, 1'b0, 1'b0);
    random_phase(STEP_RESET, 12, 59, 36, 1'b0, 1'b0);
    random_phase(17'($urandom_range(2048, 32767)), 50, 0, 0, 1'b0, 1'b0);
    random_phase(17'h1FFFF, 30, 0, 0, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d lattice values and %0d interpolated samples",
             sb.lattice_cnt, sb.sample_cnt);
    $display("over %0d fade-step writes, from zero and the minimum up to all ones",
             step_settings);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/vnsi_pkg.sv
design/vnsi_mul.sv
design/vnsi_ctrl.sv
design/value_noise_smootherstep_interp_unit.sv
dv/value_noise_smootherstep_interp_unit_tb.sv
